// ===== rtl/core/bel_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bel_pkg
// Shared constants, command codes and status bundle of the exclusion builder.
// ----------------------------------------------------------------------------
package bel_pkg;

  localparam int NUM_ATOMS   = 1024;
  localparam int ATOM_W      = 10;
  localparam int N_W         = 11;
  localparam int BOND_SLOTS  = 8;
  localparam int BOND_SW     = 3;
  localparam int BCNT_W      = 4;
  localparam int PART_SLOTS  = 32;
  localparam int PART_SW     = 5;
  localparam int ECNT_W      = 6;
  localparam int P14_DEPTH   = 4096;
  localparam int P14_AW      = 12;
  localparam int TOT_W       = 13;
  localparam int FUNC_W      = 3;
  localparam int ST_W        = 2;

  localparam logic [FUNC_W-1:0] FN_BOND     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ANGLE    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DIHEDRAL = 3'd2;
  localparam logic [FUNC_W-1:0] FN_IMPROPER = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FINISH   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RD_EXCL  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RD_P14   = 3'd6;
  localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd7;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_PHASE    = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd3;

  typedef enum logic [5:0] {
    OP_IDLE, OP_SWEEP, OP_CHECK, OP_NOP,
    OP_BN0, OP_BN1, OP_TNEXT,
    OP_AP_RD, OP_AP_CNT, OP_AP_SCAN, OP_AP_CMP, OP_AP_P14, OP_AP_X0, OP_AP_X1,
    OP_W_IA, OP_W_IAC, OP_W_J, OP_W_JD, OP_W_IB, OP_W_IBC, OP_W_K, OP_W_KD,
    OP_W_IC, OP_W_ICB, OP_W_ICC, OP_W_L, OP_W_LD, OP_W_ID,
    OP_R0, OP_R1, OP_R_SCAN, OP_R_CMP, OP_R_OUT,
    OP_P0, OP_P1, OP_EMIT
  } op_t;

  typedef struct packed {
    logic              in_fire;
    logic              err;
    logic [FUNC_W-1:0] fn;
    logic              sec;
    logic              term_end;
    logic              scan_end;
    logic              hit;
    logic              sweep_done;
    logic              ia_end;
    logic              j_end;
    logic              k_end;
    logic              ic_self;
    logic              l_end;
    logic              id_skip;
    logic              out_load;
    logic              out_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/bel_item_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bel_item_if
// Input channel: one term, finish, read or clear request per transaction.
// ----------------------------------------------------------------------------
interface bel_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [9:0]  atom_a;
  logic [9:0]  atom_b;
  logic [9:0]  atom_c;
  logic [9:0]  atom_d;
  logic [11:0] pair_index;

  modport source (output valid, func, atom_a, atom_b, atom_c, atom_d, pair_index,
                  input ready);
  modport sink (input valid, func, atom_a, atom_b, atom_c, atom_d, pair_index,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bel_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bel_result_if
// Output channel: one result per transaction.
// ----------------------------------------------------------------------------
interface bel_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  partner_atom;
  logic [9:0]  other_atom;
  logic [5:0]  entry_count;
  logic [12:0] pair14_count;
  logic        last;

  modport source (output valid, status, partner_atom, other_atom, entry_count,
                  pair14_count, last, input ready);
  modport sink (input valid, status, partner_atom, other_atom, entry_count,
                pair14_count, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bel_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bel_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/bel_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bel_ctrl
// Sequencer for terms, pair insertion, graph walk, reads and clearing.
// ----------------------------------------------------------------------------
module bel_ctrl import bel_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output op_t   cmd
);

  typedef enum logic [35:0] {
    S_CLR    = 36'd1 << 0,  S_IDLE   = 36'd1 << 1,  S_CHECK  = 36'd1 << 2,
    S_DISP   = 36'd1 << 3,  S_BN0    = 36'd1 << 4,  S_BN1    = 36'd1 << 5,
    S_TNEXT  = 36'd1 << 6,  S_AP_RD  = 36'd1 << 7,  S_AP_CNT = 36'd1 << 8,
    S_AP_SCAN = 36'd1 << 9, S_AP_CMP = 36'd1 << 10, S_AP_P14 = 36'd1 << 11,
    S_AP_X0  = 36'd1 << 12, S_AP_X1  = 36'd1 << 13, S_W_IA   = 36'd1 << 14,
    S_W_IAC  = 36'd1 << 15, S_W_J    = 36'd1 << 16, S_W_JD   = 36'd1 << 17,
    S_W_IB   = 36'd1 << 18, S_W_IBC  = 36'd1 << 19, S_W_K    = 36'd1 << 20,
    S_W_KD   = 36'd1 << 21, S_W_IC   = 36'd1 << 22, S_W_ICB  = 36'd1 << 23,
    S_W_ICC  = 36'd1 << 24, S_W_L    = 36'd1 << 25, S_W_LD   = 36'd1 << 26,
    S_W_ID   = 36'd1 << 27, S_R0     = 36'd1 << 28, S_R1     = 36'd1 << 29,
    S_R_SCAN = 36'd1 << 30, S_R_CMP  = 36'd1 << 31, S_R_OUT  = 36'd1 << 32,
    S_P0     = 36'd1 << 33, S_P1     = 36'd1 << 34, S_EMIT   = 36'd1 << 35
  } state_t;

  typedef enum logic [1:0] {RET_TERM, RET_EMIT, RET_W3, RET_W4} ret_t;

  state_t state, state_next;
  ret_t   ret, ret_next;
  logic   clr_rsp, clr_rsp_next;
  state_t ret_state;

  always_comb begin
    case (ret)
      RET_TERM: ret_state = S_TNEXT;
      RET_EMIT: ret_state = S_EMIT;
      RET_W3:   ret_state = S_W_ICB;
      default:  ret_state = S_W_L;
    endcase
  end

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    clr_rsp_next = clr_rsp;
    unique case (state)
      S_CLR:     if (stat.sweep_done) state_next = clr_rsp ? S_EMIT : S_IDLE;
      S_IDLE:    if (stat.in_fire) state_next = S_CHECK;
      S_CHECK:   state_next = S_DISP;
      S_DISP: begin
        if (stat.err) begin
          state_next = S_EMIT;
        end else begin
          unique case (stat.fn)
            FN_BOND:                          state_next = S_BN0;
            FN_ANGLE, FN_DIHEDRAL, FN_IMPROPER: state_next = S_TNEXT;
            FN_FINISH:                        state_next = S_W_IA;
            FN_RD_EXCL:                       state_next = S_R0;
            FN_RD_P14:                        state_next = S_P0;
            default: begin
              state_next   = S_CLR;
              clr_rsp_next = 1'b1;
            end
          endcase
        end
      end
      S_BN0:     state_next = S_BN1;
      S_BN1: begin
        if (!stat.sec) begin
          state_next = S_BN0;
        end else begin
          state_next = S_AP_X0;
          ret_next   = RET_EMIT;
        end
      end
      S_TNEXT: begin
        if (stat.term_end) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_AP_RD;
          ret_next   = RET_TERM;
        end
      end
      S_AP_RD:   state_next = S_AP_CNT;
      S_AP_CNT:  state_next = S_AP_SCAN;
      S_AP_SCAN: state_next = stat.scan_end ? S_AP_P14 : S_AP_CMP;
      S_AP_CMP:  state_next = stat.hit ? ret_state : S_AP_SCAN;
      S_AP_P14:  state_next = S_AP_X0;
      S_AP_X0:   state_next = S_AP_X1;
      S_AP_X1:   state_next = stat.sec ? ret_state : S_AP_X0;
      S_W_IA:    state_next = stat.ia_end ? S_EMIT : S_W_IAC;
      S_W_IAC:   state_next = S_W_J;
      S_W_J:     state_next = stat.j_end ? S_W_IA : S_W_JD;
      S_W_JD:    state_next = S_W_IB;
      S_W_IB:    state_next = S_W_IBC;
      S_W_IBC:   state_next = S_W_K;
      S_W_K:     state_next = stat.k_end ? S_W_J : S_W_KD;
      S_W_KD:    state_next = S_W_IC;
      S_W_IC: begin
        if (stat.ic_self) begin
          state_next = S_W_K;
        end else begin
          state_next = S_AP_RD;
          ret_next   = RET_W3;
        end
      end
      S_W_ICB:   state_next = S_W_ICC;
      S_W_ICC:   state_next = S_W_L;
      S_W_L:     state_next = stat.l_end ? S_W_K : S_W_LD;
      S_W_LD:    state_next = S_W_ID;
      S_W_ID: begin
        if (stat.id_skip) begin
          state_next = S_W_L;
        end else begin
          state_next = S_AP_RD;
          ret_next   = RET_W4;
        end
      end
      S_R0:      state_next = S_R1;
      S_R1:      state_next = S_R_SCAN;
      S_R_SCAN:  state_next = stat.scan_end ? S_R_OUT : S_R_CMP;
      S_R_CMP:   state_next = S_R_SCAN;
      S_R_OUT:   if (stat.out_load && stat.out_last) state_next = S_IDLE;
      S_P0:      state_next = S_P1;
      S_P1:      state_next = S_EMIT;
      S_EMIT: begin
        if (stat.out_load) begin
          state_next   = S_IDLE;
          clr_rsp_next = 1'b0;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      S_CLR:     cmd = OP_SWEEP;
      S_IDLE:    cmd = OP_IDLE;
      S_CHECK:   cmd = OP_CHECK;
      S_DISP:    cmd = OP_NOP;
      S_BN0:     cmd = OP_BN0;
      S_BN1:     cmd = OP_BN1;
      S_TNEXT:   cmd = OP_TNEXT;
      S_AP_RD:   cmd = OP_AP_RD;
      S_AP_CNT:  cmd = OP_AP_CNT;
      S_AP_SCAN: cmd = OP_AP_SCAN;
      S_AP_CMP:  cmd = OP_AP_CMP;
      S_AP_P14:  cmd = OP_AP_P14;
      S_AP_X0:   cmd = OP_AP_X0;
      S_AP_X1:   cmd = OP_AP_X1;
      S_W_IA:    cmd = OP_W_IA;
      S_W_IAC:   cmd = OP_W_IAC;
      S_W_J:     cmd = OP_W_J;
      S_W_JD:    cmd = OP_W_JD;
      S_W_IB:    cmd = OP_W_IB;
      S_W_IBC:   cmd = OP_W_IBC;
      S_W_K:     cmd = OP_W_K;
      S_W_KD:    cmd = OP_W_KD;
      S_W_IC:    cmd = OP_W_IC;
      S_W_ICB:   cmd = OP_W_ICB;
      S_W_ICC:   cmd = OP_W_ICC;
      S_W_L:     cmd = OP_W_L;
      S_W_LD:    cmd = OP_W_LD;
      S_W_ID:    cmd = OP_W_ID;
      S_R0:      cmd = OP_R0;
      S_R1:      cmd = OP_R1;
      S_R_SCAN:  cmd = OP_R_SCAN;
      S_R_CMP:   cmd = OP_R_CMP;
      S_R_OUT:   cmd = OP_R_OUT;
      S_P0:      cmd = OP_P0;
      S_P1:      cmd = OP_P1;
      S_EMIT:    cmd = OP_EMIT;
      default:   cmd = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      ret     <= RET_EMIT;
      clr_rsp <= 1'b0;
    end else begin
      state   <= state_next;
      ret     <= ret_next;
      clr_rsp <= clr_rsp_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bel_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bel_datapath
// List memories, walk counters, sorted read buffer and result register.
// ----------------------------------------------------------------------------
module bel_datapath import bel_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [N_W-1:0]     cfg_wr_data,
  bel_item_if.sink           item,
  bel_result_if.source       result,
  input  op_t                cmd,
  output stat_t              stat
);

  localparam logic [2:0] TERM_END = 3'd6;
  localparam int BL_AW = $clog2(NUM_ATOMS * BOND_SLOTS);
  localparam int EL_AW = $clog2(NUM_ATOMS * PART_SLOTS);

  // configuration and sticky state
  logic [N_W-1:0]    n;
  logic              finished;
  logic              ovf;
  logic [TOT_W-1:0]  total;

  // latched request
  logic [FUNC_W-1:0] fn;
  logic [ATOM_W-1:0] a, b, c, d;
  logic [P14_AW-1:0] pidx;
  logic              err_ph, err_rg;

  // pair insertion
  logic [ATOM_W-1:0] px, py;
  logic              prec, sec;
  logic [ECNT_W-1:0] xcnt, s;
  logic [2:0]        t;

  // graph walk
  logic [N_W-1:0]    ia;
  logic [BCNT_W-1:0] j, jn, k, kn, l, ln;
  logic [ATOM_W-1:0] ib, ic, id;

  logic [ATOM_W-1:0] clr;
  logic [2*ATOM_W-1:0] pv;

  // sorted read buffer, stored as distance above the queried atom
  logic [ATOM_W-1:0] keys [PART_SLOTS];
  logic [ATOM_W-1:0] keys_next [PART_SLOTS];
  logic [PART_SLOTS-1:0] gt;
  logic [ECNT_W-1:0] cnt, o;

  // result register
  logic              out_valid;
  logic [ST_W-1:0]   out_status;
  logic [ATOM_W-1:0] out_partner, out_other;
  logic [ECNT_W-1:0] out_count;
  logic [TOT_W-1:0]  out_p14;
  logic              out_last;

  // memories
  logic                bcnt_we, blist_we, ecnt_we, elist_we, p14_we;
  logic [ATOM_W-1:0]   bcnt_wa, bcnt_ra, ecnt_wa, ecnt_ra;
  logic [BCNT_W-1:0]   bcnt_wd, bcnt_rd;
  logic [ECNT_W-1:0]   ecnt_wd, ecnt_rd;
  logic [BL_AW-1:0]    blist_wa, blist_ra;
  logic [ATOM_W-1:0]   blist_wd, blist_rd;
  logic [EL_AW-1:0]    elist_wa, elist_ra;
  logic [ATOM_W-1:0]   elist_wd, elist_rd;
  logic [P14_AW-1:0]   p14_ra;
  logic [2*ATOM_W-1:0] p14_rd;

  bel_ram #(.WIDTH(BCNT_W), .DEPTH(NUM_ATOMS)) u_bcnt (
    .clk(clk), .we(bcnt_we), .waddr(bcnt_wa), .wdata(bcnt_wd),
    .raddr(bcnt_ra), .rdata(bcnt_rd));
  bel_ram #(.WIDTH(ATOM_W), .DEPTH(NUM_ATOMS * BOND_SLOTS)) u_blist (
    .clk(clk), .we(blist_we), .waddr(blist_wa), .wdata(blist_wd),
    .raddr(blist_ra), .rdata(blist_rd));
  bel_ram #(.WIDTH(ECNT_W), .DEPTH(NUM_ATOMS)) u_ecnt (
    .clk(clk), .we(ecnt_we), .waddr(ecnt_wa), .wdata(ecnt_wd),
    .raddr(ecnt_ra), .rdata(ecnt_rd));
  bel_ram #(.WIDTH(ATOM_W), .DEPTH(NUM_ATOMS * PART_SLOTS)) u_elist (
    .clk(clk), .we(elist_we), .waddr(elist_wa), .wdata(elist_wd),
    .raddr(elist_ra), .rdata(elist_rd));
  bel_ram #(.WIDTH(2*ATOM_W), .DEPTH(P14_DEPTH)) u_p14 (
    .clk(clk), .we(p14_we), .waddr(total[P14_AW-1:0]), .wdata({px, py}),
    .raddr(p14_ra), .rdata(p14_rd));

  logic [ATOM_W-1:0] own_x, val_x, own_b, val_b;
  logic [ATOM_W-1:0] tx, ty;
  logic [2:0]        t_next;
  logic              load;
  logic [ST_W-1:0]   st_code;
  logic [N_W-1:0]    e11, a11, h, hm;
  logic              keep;
  logic [ATOM_W-1:0] knew;
  logic [N_W-1:0]    cfg_n;

  assign own_x = sec ? py : px;
  assign val_x = sec ? px : py;
  assign own_b = sec ? b : a;
  assign val_b = sec ? a : b;

  always_comb begin
    case (t)
      3'd0:    begin tx = a; ty = b; end
      3'd1:    begin tx = a; ty = c; end
      3'd2:    begin tx = a; ty = d; end
      3'd3:    begin tx = b; ty = c; end
      3'd4:    begin tx = b; ty = d; end
      default: begin tx = c; ty = d; end
    endcase
    if (fn == FN_ANGLE) begin
      case (t)
        3'd0:    t_next = 3'd1;
        3'd1:    t_next = 3'd3;
        default: t_next = TERM_END;
      endcase
    end else begin
      t_next = t + 3'd1;
    end
  end

  // half minimum-image window
  assign e11  = {1'b0, elist_rd};
  assign a11  = {1'b0, a};
  assign h    = n >> 1;
  assign hm   = (n - 11'd1) >> 1;
  assign keep = (e11 > a11 && (e11 - a11) < h) || (e11 < a11 && (n - (a11 - e11)) < hm);
  assign knew = elist_rd - a;

  // parallel insertion: an entry moves up one slot when it ranks above the new one
  for (genvar p = 0; p < PART_SLOTS; p++) begin : g_ins
    assign gt[p] = (ECNT_W'(p) >= cnt) || (keys[p] > knew);
    if (p == 0) begin : g_first
      assign keys_next[p] = gt[p] ? knew : keys[p];
    end else begin : g_rest
      assign keys_next[p] = gt[p] ? (gt[p-1] ? keys[p-1] : knew) : keys[p];
    end
  end

  assign load    = !out_valid || result.ready;
  assign st_code = err_ph ? ST_PHASE : err_rg ? ST_RANGE : ovf ? ST_OVERFLOW : ST_OK;
  assign cfg_n   = (cfg_wr_data == '0) ? N_W'(1) :
                   (cfg_wr_data > N_W'(NUM_ATOMS)) ? N_W'(NUM_ATOMS) : cfg_wr_data;

  assign item.ready = (cmd == OP_IDLE);

  always_comb begin
    stat            = '0;
    stat.in_fire    = item.valid && item.ready;
    stat.err        = err_ph || err_rg;
    stat.fn         = fn;
    stat.sec        = sec;
    stat.term_end   = (t == TERM_END);
    stat.scan_end   = (s == xcnt);
    stat.hit        = (elist_rd == py);
    stat.sweep_done = &clr;
    stat.ia_end     = (ia == n);
    stat.j_end      = (j == jn);
    stat.k_end      = (k == kn);
    stat.ic_self    = (ic == ia[ATOM_W-1:0]);
    stat.l_end      = (l == ln);
    stat.id_skip    = (id == ia[ATOM_W-1:0]) || (id == ib);
    stat.out_load   = load;
    stat.out_last   = (cnt == '0) || (o == cnt - 6'd1);
  end

  // memory ports
  always_comb begin
    bcnt_we  = 1'b0; bcnt_wa  = clr;  bcnt_wd  = '0;  bcnt_ra  = '0;
    blist_we = 1'b0; blist_wa = {own_b, bcnt_rd[BOND_SW-1:0]}; blist_wd = val_b;
    blist_ra = '0;
    ecnt_we  = 1'b0; ecnt_wa  = clr;  ecnt_wd  = '0;  ecnt_ra  = '0;
    elist_we = 1'b0; elist_wa = {own_x, ecnt_rd[PART_SW-1:0]}; elist_wd = val_x;
    elist_ra = '0;
    p14_we   = 1'b0; p14_ra   = pidx;
    case (cmd)
      OP_SWEEP: begin
        bcnt_we = 1'b1;
        ecnt_we = 1'b1;
      end
      OP_BN0:    bcnt_ra = own_b;
      OP_BN1: begin
        bcnt_we  = !bcnt_rd[BCNT_W-1];
        blist_we = !bcnt_rd[BCNT_W-1];
        bcnt_wa  = own_b;
        bcnt_wd  = bcnt_rd + 4'd1;
      end
      OP_AP_RD:  ecnt_ra = px;
      OP_AP_SCAN: elist_ra = {px, s[PART_SW-1:0]};
      OP_AP_P14: p14_we = prec && !total[TOT_W-1];
      OP_AP_X0:  ecnt_ra = own_x;
      OP_AP_X1: begin
        ecnt_we  = !ecnt_rd[ECNT_W-1];
        elist_we = !ecnt_rd[ECNT_W-1];
        ecnt_wa  = own_x;
        ecnt_wd  = ecnt_rd + 6'd1;
      end
      OP_W_IA:   bcnt_ra = ia[ATOM_W-1:0];
      OP_W_J:    blist_ra = {ia[ATOM_W-1:0], j[BOND_SW-1:0]};
      OP_W_IB:   bcnt_ra = ib;
      OP_W_K:    blist_ra = {ib, k[BOND_SW-1:0]};
      OP_W_ICB:  bcnt_ra = ic;
      OP_W_L:    blist_ra = {ic, l[BOND_SW-1:0]};
      OP_R0:     ecnt_ra = a;
      OP_R_SCAN: elist_ra = {a, s[PART_SW-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= N_W'(NUM_ATOMS);
      finished  <= 1'b0;
      ovf       <= 1'b0;
      total     <= '0;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        n <= cfg_n;
      end
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        OP_IDLE: begin
          if (item.valid) begin
            fn   <= item.func;
            a    <= item.atom_a;
            b    <= item.atom_b;
            c    <= item.atom_c;
            d    <= item.atom_d;
            pidx <= item.pair_index;
          end
        end
        OP_SWEEP: begin
          clr      <= clr + 10'd1;
          finished <= 1'b0;
          ovf      <= 1'b0;
          total    <= '0;
        end
        OP_CHECK: begin
          t   <= 3'd0;
          sec <= 1'b0;
          ia  <= '0;
          if (fn <= FN_FINISH) begin
            err_ph <= finished;
            err_rg <= (fn != FN_FINISH) &&
                      ({1'b0, a} >= n || {1'b0, b} >= n ||
                       (fn != FN_BOND && {1'b0, c} >= n) ||
                       ((fn == FN_DIHEDRAL || fn == FN_IMPROPER) && {1'b0, d} >= n));
          end else if (fn == FN_RD_EXCL) begin
            err_ph <= !finished;
            err_rg <= {1'b0, a} >= n;
          end else if (fn == FN_RD_P14) begin
            err_ph <= !finished;
            err_rg <= {1'b0, pidx} >= total;
          end else begin
            err_ph <= 1'b0;
            err_rg <= 1'b0;
          end
        end
        OP_BN1: begin
          if (bcnt_rd[BCNT_W-1]) ovf <= 1'b1;
          sec <= !sec;
          if (sec) begin
            px <= a;
            py <= b;
          end
        end
        OP_TNEXT: begin
          if (t != TERM_END) begin
            px   <= tx;
            py   <= ty;
            prec <= (t == 3'd2) && (fn == FN_DIHEDRAL);
            sec  <= 1'b0;
            t    <= t_next;
          end
        end
        OP_AP_CNT: begin
          xcnt <= ecnt_rd;
          s    <= '0;
        end
        OP_AP_CMP: s <= s + 6'd1;
        OP_AP_P14: begin
          if (prec) begin
            if (!total[TOT_W-1]) total <= total + 13'd1;
            else                 ovf   <= 1'b1;
          end
        end
        OP_AP_X1: begin
          if (ecnt_rd[ECNT_W-1]) ovf <= 1'b1;
          sec <= !sec;
        end
        OP_W_IA:  if (ia == n) finished <= 1'b1;
        OP_W_IAC: begin
          jn <= bcnt_rd;
          j  <= '0;
        end
        OP_W_J:   if (j == jn) ia <= ia + 11'd1;
        OP_W_JD: begin
          ib <= blist_rd;
          j  <= j + 4'd1;
        end
        OP_W_IBC: begin
          kn <= bcnt_rd;
          k  <= '0;
        end
        OP_W_KD: begin
          ic <= blist_rd;
          k  <= k + 4'd1;
        end
        OP_W_IC: begin
          px   <= ia[ATOM_W-1:0];
          py   <= ic;
          prec <= 1'b0;
          sec  <= 1'b0;
        end
        OP_W_ICC: begin
          ln <= bcnt_rd;
          l  <= '0;
        end
        OP_W_LD: begin
          id <= blist_rd;
          l  <= l + 4'd1;
        end
        OP_W_ID: begin
          px   <= ia[ATOM_W-1:0];
          py   <= id;
          prec <= 1'b1;
          sec  <= 1'b0;
        end
        OP_R1: begin
          xcnt <= ecnt_rd;
          s    <= '0;
          cnt  <= '0;
          o    <= '0;
        end
        OP_R_CMP: begin
          s <= s + 6'd1;
          if (keep) begin
            keys <= keys_next;
            cnt  <= cnt + 6'd1;
          end
        end
        OP_R_OUT: begin
          if (load) begin
            out_valid  <= 1'b1;
            out_status <= st_code;
            out_other  <= '0;
            out_p14    <= total;
            out_count  <= cnt;
            if (cnt == '0) begin
              out_partner <= '0;
              out_last    <= 1'b1;
            end else begin
              out_partner <= keys[o[PART_SW-1:0]] + a;
              out_last    <= (o == cnt - 6'd1);
            end
            o <= o + 6'd1;
          end
        end
        OP_P1: pv <= p14_rd;
        OP_EMIT: begin
          if (load) begin
            out_valid  <= 1'b1;
            out_status <= st_code;
            out_count  <= '0;
            out_p14    <= total;
            out_last   <= 1'b1;
            if (fn == FN_RD_P14 && !err_ph && !err_rg) begin
              out_partner <= pv[2*ATOM_W-1:ATOM_W];
              out_other   <= pv[ATOM_W-1:0];
            end else begin
              out_partner <= '0;
              out_other   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.partner_atom = out_partner;
  assign result.other_atom   = out_other;
  assign result.entry_count  = out_count;
  assign result.pair14_count = out_p14;
  assign result.last         = out_last;

endmodule
`default_nettype wire

// ===== rtl/core/bonded_exclusion_list_builder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bonded_exclusion_list_builder
// Builds 1-2, 1-3 and 1-4 exclusion lists and the 1-4 pair table.
// ----------------------------------------------------------------------------
// One request is handled at a time; the next is taken once the previous one
// has placed its last result in the output register. All lists sit in
// single-port-read RAMs, so timing follows the list scans: a bond reads and
// bumps the bond count of each atom, then inserts the pair both ways, and
// each pair of an angle or torsion first scans the entries already listed
// for its first atom. Finish walks the bond graph and makes one pair
// insertion per 1-3 and 1-4 candidate. A read of exclusions scans every
// stored entry, then gives one result per cycle while the output is accepted;
// a 1-4 pair read reads the pair table once. After reset, and on every clear,
// all 1024 count entries are swept before the next request is accepted.
// ----------------------------------------------------------------------------
module bonded_exclusion_list_builder import bel_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [N_W-1:0]  cfg_wr_data,
  bel_item_if.sink        item,
  bel_result_if.source    result
);

  op_t   cmd;
  stat_t stat;

  bel_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  bel_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .result      (result),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
`default_nettype wire
